// ===== src/mt_rng_pkg.sv =====
// Constants, codes and the tempering function of the MT19937 generator.
package mt_rng_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = 10;
	localparam int WORD_W       = 32;
	localparam int ACTION_W     = 2;

	localparam logic [IDX_W-1:0] INDEX_FULL   = IDX_W'(STATE_WORDS);
	localparam logic [IDX_W-1:0] INDEX_UNINIT = IDX_W'(STATE_WORDS + 1);
	localparam logic [IDX_W-1:0] INDEX_LAST   = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] OFFSET_FWD   = IDX_W'(TWIST_OFFSET);
	localparam logic [IDX_W-1:0] OFFSET_BACK  = IDX_W'(STATE_WORDS - TWIST_OFFSET);

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] KNUTH_MULT   = 32'd1812433253;
	localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

	localparam logic [ACTION_W-1:0] ACT_NEXT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BOUNDED = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== src/mt19937_random_generator.sv =====
// MT19937 generator: state memory, seed fill, twist sweep, tempering and bounded reduction.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  action, bound
//   out       source     out_valid / out_stall value
//   cfg       sink       cfg_we               cfg_wdata (seed)
//
// A plain draw or peek passes the decide, read, data and done states on its way from accept to the
// output register; a bounded draw adds the bit-serial remainder unit.
// When the read index is used up the twist sweep runs first, a read and a write state per
// word over the one state memory; after reset or a seed write the seed fill runs before it.
// Reset leaves the memory untouched; the index starts as uninitialized, so no clearing pass.
// One request is in work at a time; a stalled result in the output register does not block the next accept.
module mt19937_random_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mt_rng_pkg::WORD_W-1:0]      cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [mt_rng_pkg::ACTION_W-1:0]    action,
	input  logic [mt_rng_pkg::WORD_W-1:0]      bound,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mt_rng_pkg::WORD_W-1:0]      value
);
	import mt_rng_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECIDE   = 4'd1;
	localparam logic [3:0] S_FILL     = 4'd2;
	localparam logic [3:0] S_TW_PRIME = 4'd3;
	localparam logic [3:0] S_TW_LOAD  = 4'd4;
	localparam logic [3:0] S_TW_RD    = 4'd5;
	localparam logic [3:0] S_TW_WR    = 4'd6;
	localparam logic [3:0] S_RD       = 4'd7;
	localparam logic [3:0] S_DATA     = 4'd8;
	localparam logic [3:0] S_DIV      = 4'd9;
	localparam logic [3:0] S_DONE     = 4'd10;

	logic [3:0]          state_q;
	idx_t                idx_q;
	idx_t                cnt_q;
	word_t               seed_q;
	logic [ACTION_W-1:0] act_q;
	word_t               bnd_q;
	word_t               prev_q;
	word_t               cur_q;
	word_t               res_q;
	word_t               dvd_q;
	word_t               rem_q;
	logic [4:0]          dcnt_q;
	logic                out_valid_q;
	word_t               value_q;

	word_t mem [STATE_WORDS];
	word_t rd_a_q;
	word_t rd_b_q;
	idx_t  raddr_a;
	idx_t  raddr_b;
	logic  mem_we;
	idx_t  mem_waddr;
	word_t mem_wdata;

	word_t           fill_word;
	word_t           twist_y;
	word_t           twist_word;
	logic [WORD_W:0] rem_shift;
	logic [WORD_W:0] rem_next;
	logic            small_bound;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;

	assign small_bound = (bnd_q <= 32'd1);

	// Knuth seed recurrence; the first word is the seed itself.
	always_comb begin
		fill_word = (prev_q ^ (prev_q >> 30)) * KNUTH_MULT + {22'd0, cnt_q};
		if (cnt_q == '0) begin
			fill_word = seed_q;
		end
	end

	// Twist of word k: cur_q holds w[k], port A w[k+1], port B w[k+397], all already
	// updated where the sweep has passed them.
	assign twist_y    = {cur_q[WORD_W-1], rd_a_q[WORD_W-2:0]};
	assign twist_word = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

	assign rem_shift = {rem_q, dvd_q[WORD_W-1]};
	assign rem_next  = (rem_shift >= {1'b0, bnd_q}) ? rem_shift - {1'b0, bnd_q} : rem_shift;

	always_comb begin
		raddr_a   = '0;
		raddr_b   = '0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = fill_word;
		unique case (state_q)
			S_FILL: begin
				mem_we = 1'b1;
			end
			S_TW_RD: begin
				raddr_a = (cnt_q == INDEX_LAST) ? '0 : cnt_q + 10'd1;
				raddr_b = (cnt_q < OFFSET_BACK) ? cnt_q + OFFSET_FWD : cnt_q - OFFSET_BACK;
			end
			S_TW_WR: begin
				mem_we    = 1'b1;
				mem_wdata = twist_word;
			end
			S_RD: begin
				raddr_a = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= INDEX_UNINIT;
			seed_q      <= SEED_RESET;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the done state the output register is handled by that state alone.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						seed_q <= cfg_wdata;
						idx_q  <= INDEX_UNINIT;
					end
					if (in_valid) begin
						act_q   <= action;
						bnd_q   <= bound;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if (act_q == ACT_NONE || (act_q == ACT_BOUNDED && small_bound)) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else if (idx_q == INDEX_UNINIT) begin
						state_q <= S_FILL;
					end else if (idx_q == INDEX_FULL) begin
						state_q <= S_TW_PRIME;
					end else begin
						state_q <= S_RD;
					end
				end
				S_FILL: begin
					prev_q <= fill_word;
					if (cnt_q == INDEX_LAST) begin
						state_q <= S_TW_PRIME;
					end else begin
						cnt_q <= cnt_q + 10'd1;
					end
				end
				S_TW_PRIME: begin
					state_q <= S_TW_LOAD;
				end
				S_TW_LOAD: begin
					cur_q   <= rd_a_q;
					cnt_q   <= '0;
					state_q <= S_TW_RD;
				end
				S_TW_RD: begin
					state_q <= S_TW_WR;
				end
				S_TW_WR: begin
					cur_q <= rd_a_q;
					if (cnt_q == INDEX_LAST) begin
						idx_q   <= '0;
						state_q <= S_RD;
					end else begin
						cnt_q   <= cnt_q + 10'd1;
						state_q <= S_TW_RD;
					end
				end
				S_RD: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					if (act_q == ACT_PEEK) begin
						res_q   <= rd_a_q;
						state_q <= S_DONE;
					end else if (act_q == ACT_BOUNDED) begin
						idx_q   <= idx_q + 10'd1;
						dvd_q   <= temper(rd_a_q);
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end else begin
						idx_q   <= idx_q + 10'd1;
						res_q   <= temper(rd_a_q);
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					rem_q  <= rem_next[WORD_W-1:0];
					dvd_q  <= dvd_q << 1;
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						res_q   <= rem_next[WORD_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// The result waits here until the output register is free.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						value_q     <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= INDEX_UNINIT)
		else $error("read index out of range");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_waddr <= INDEX_LAST)
		else $error("state memory write beyond last word");

	a_read_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> idx_q <= INDEX_LAST)
		else $error("draw from a used-up or uninitialized store");

	a_mod_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && act_q == ACT_BOUNDED && !small_bound) |-> res_q < bnd_q)
		else $error("bounded draw not below its bound");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("output beat raised outside the done state");

endmodule

// ===== verif/mt_rng_checker.sv =====
// Checker for the MT19937 generator: predicts every value from the accepted requests and compares.
module mt_rng_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  mt_rng_pkg::word_t               cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [mt_rng_pkg::ACTION_W-1:0] action,
	input  mt_rng_pkg::word_t               bound,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  mt_rng_pkg::word_t               value,
	output int                              fails,
	output int                              outstanding,
	output int                              checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import mt_rng_pkg::*;

	localparam int    POOL_SIZE     = 624;
	localparam int    TWIST_SKIP    = 397;
	localparam int    POOL_UNSEEDED = POOL_SIZE + 1;
	localparam word_t TWIST_XOR     = 32'h9908_b0df;
	localparam word_t HIGH_MASK     = 32'h8000_0000;
	localparam word_t LOW_MASK      = 32'h7fff_ffff;
	localparam word_t SEED_MULT     = 32'd1812433253;
	localparam word_t SHAPE_B       = 32'h9d2c_5680;
	localparam word_t SHAPE_C       = 32'hefc6_0000;
	localparam word_t DEFAULT_SEED  = 32'd5489;

	word_t pool [POOL_SIZE];
	int    pool_pos;
	word_t seed_word;
	word_t value_q [$];
	word_t wanted;

	function automatic void seed_pool();
		pool[0] = seed_word;
		for (int i = 1; i < POOL_SIZE; i++)
			pool[i] = SEED_MULT * (pool[i-1] ^ (pool[i-1] >> 30)) + word_t'(i);
	endfunction

	// Rebuilds the whole pool; an unseeded pool is filled from the seed first.
	function automatic void twist_pool();
		word_t y;
		if (pool_pos == POOL_UNSEEDED)
			seed_pool();
		for (int k = 0; k < POOL_SIZE; k++) begin
			y = (pool[k] & HIGH_MASK) | (pool[(k + 1) % POOL_SIZE] & LOW_MASK);
			pool[k] = pool[(k + TWIST_SKIP) % POOL_SIZE] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
		end
		pool_pos = 0;
	endfunction

	function automatic word_t shape_word(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & SHAPE_B);
		y = y ^ ((y << 15) & SHAPE_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic word_t draw_word();
		word_t y;
		if (pool_pos >= POOL_SIZE)
			twist_pool();
		y = pool[pool_pos];
		pool_pos++;
		return shape_word(y);
	endfunction

	function automatic word_t predict_value(input logic [ACTION_W-1:0] act, input word_t bnd);
		word_t v;
		v = '0;
		case (act)
			ACT_NEXT: v = draw_word();
			ACT_BOUNDED: begin
				// A bound of 0 or 1 leaves the pool and the position alone.
				if (bnd > 1)
					v = draw_word() % bnd;
			end
			ACT_PEEK: begin
				if (pool_pos >= POOL_SIZE)
					twist_pool();
				v = pool[pool_pos];
			end
			default: v = '0;
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_pos = POOL_UNSEEDED;
			seed_word = DEFAULT_SEED;
			value_q.delete();
			fails = 0;
			checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				seed_word = cfg_wdata;
				pool_pos = POOL_UNSEEDED;
			end
			if (in_valid && !in_stall)
				value_q.push_back(predict_value(action, bound));
			if (out_valid && !out_stall) begin
				if (value_q.size() == 0) begin
					fails++;
					$error("value %h delivered with no request waiting", value);
				end else begin
					wanted = value_q.pop_front();
					checked++;
					if (value !== wanted) begin
						fails++;
						$error("value mismatch: expected %h, got %h", wanted, value);
					end
				end
			end
			outstanding <= value_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the MT19937 generator testbench: clock, reset, request and seed stimulus, verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mt_rng_pkg::*;

	localparam int LIMIT_CYCLES      = 1_000_000;
	localparam int HOLD_CYCLES       = 400;
	localparam int IDLE_SETTLE       = 8;
	localparam int TAIL_CYCLES       = 64;
	localparam int SHORT_PHASE_ITEMS = 40;
	localparam int LONG_PHASE_DRAWS  = 390;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	word_t               cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [ACTION_W-1:0] action = ACT_NEXT;
	word_t               bound = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	word_t               value;

	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int   fails;
	int   outstanding;
	int   checked;
	int   n_next, n_bounded, n_peek, n_none, n_seeds;

	mt19937_random_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.bound     (bound),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	mt_rng_checker watcher (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.bound       (bound),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.fails       (fails),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Result side: random stalls, none while calm, and one long hold on request.
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 32);
			end
		end
	end

	// Called in step with the rising clock; returns once the generator has taken the request.
	task automatic send_request(input logic [ACTION_W-1:0] act, input word_t bnd);
		while (!calm && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			action <= ACTION_W'($urandom);
			bound <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		bound <= bnd;
		case (act)
			ACT_NEXT:    n_next++;
			ACT_BOUNDED: n_bounded++;
			ACT_PEEK:    n_peek++;
			default:     n_none++;
		endcase
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_seed(input word_t s);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_seeds++;
	endtask

	function automatic bit pick_request(output logic [ACTION_W-1:0] act, output word_t bnd);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			act = ACT_NEXT;
		else if (r < 88)
			act = ACT_BOUNDED;
		else if (r < 96)
			act = ACT_PEEK;
		else
			act = ACT_NONE;
		r = $urandom_range(0, 99);
		if (r < 10)
			bnd = word_t'($urandom_range(0, 1));
		else if (r < 25)
			bnd = word_t'($urandom_range(2, 16));
		else
			bnd = $urandom;
		// True when the request moves the read position forward.
		return act == ACT_NEXT || (act == ACT_BOUNDED && bnd > 1);
	endfunction

	task automatic random_requests(input int count);
		logic [ACTION_W-1:0] act;
		word_t               bnd;
		for (int k = 0; k < count; k++) begin
			void'(pick_request(act, bnd));
			send_request(act, bnd);
		end
	endtask

	initial begin
		logic [ACTION_W-1:0] act;
		word_t               bnd;
		int                  advanced;
		int                  k;
		n_next = 0;
		n_bounded = 0;
		n_peek = 0;
		n_none = 0;
		n_seeds = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset seed: the first request is a peek, so it alone seeds and twists the pool.
		send_request(ACT_PEEK, $urandom);
		send_request(ACT_NEXT, $urandom);
		send_request(ACT_PEEK, $urandom);
		send_request(ACT_BOUNDED, 32'd0);
		send_request(ACT_BOUNDED, 32'd1);
		send_request(ACT_BOUNDED, 32'd2);
		send_request(ACT_BOUNDED, 32'd3);
		send_request(ACT_BOUNDED, 32'hffff_ffff);
		send_request(ACT_BOUNDED, 32'h8000_0000);
		send_request(ACT_BOUNDED, 32'h7fff_ffff);
		send_request(ACT_NONE, 32'hffff_ffff);
		send_request(ACT_NONE, 32'd0);
		send_request(ACT_NEXT, 32'hffff_ffff);
		send_request(ACT_PEEK, 32'd0);

		// A small bound and an unused code on a fresh seed must not start the fill.
		write_seed(32'd0);
		send_request(ACT_BOUNDED, 32'd1);
		send_request(ACT_NONE, $urandom);
		send_request(ACT_BOUNDED, 32'd0);
		send_request(ACT_NEXT, $urandom);
		random_requests(SHORT_PHASE_ITEMS);

		write_seed(32'hffff_ffff);
		send_request(ACT_BOUNDED, 32'hffff_ffff);
		send_request(ACT_PEEK, $urandom);
		random_requests(SHORT_PHASE_ITEMS);

		// Long phase: mixed traffic with one long result hold, a stretch without idling
		// and a pause until every result is back.
		write_seed($urandom);
		advanced = 0;
		k = 0;
		while (advanced < LONG_PHASE_DRAWS) begin
			if (k == 80)
				hold_req <= 1'b1;
			if (k == 150)
				calm <= 1'b1;
			if (k == 300)
				calm <= 1'b0;
			if (k == 360)
				wait_idle();
			if (pick_request(act, bnd))
				advanced++;
			send_request(act, bnd);
			k++;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected values never delivered", outstanding);
		$display("Covered %0d requests: %0d draws, %0d bounded, %0d peeks, %0d unused codes.",
			n_next + n_bounded + n_peek + n_none, n_next, n_bounded, n_peek, n_none);
		$display("Seeds used: %0d, both extremes among them; %0d values compared.",
			n_seeds, checked);
		if (fails == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$error("run exceeded %0d cycles", LIMIT_CYCLES);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
